// ===== hw/rtl/fzrrip_pkg.sv =====
// Shared types, constants and the insertion table of the fuzzy RRIP policy.
`timescale 1ns / 1ps

package fzrrip_pkg;

  // Policy sizing
  localparam int unsigned RrpvBits = 2;
  localparam int unsigned HeatMax  = 31;

  // Field widths
  localparam int unsigned RrpvW  = 2;
  localparam int unsigned HeatW  = 5;
  localparam int unsigned TickW  = 64;
  localparam int unsigned CntW   = 32;
  localparam int unsigned RowW   = 3;
  localparam int unsigned AlphaW = 7;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgImmThr   = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNearThr  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTuneIntv = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgHitZero  = 2'd3;

  // Configuration and miss-row reset values
  localparam logic [AlphaW-1:0] ImmThrRst   = 7'd85;
  localparam logic [AlphaW-1:0] NearThrRst  = 7'd40;
  localparam logic [CntW-1:0]   TuneIntvRst = 32'd1000000;
  localparam logic [RowW-1:0]   MissRowRst  = 3'd3;

  // Largest RRPV the policy uses, at the width of the field
  localparam logic [RrpvW-1:0] RrpvMax = RrpvW'((1 << RrpvBits) - 1);

  typedef enum logic [1:0] {
    CLS_IMMEDIATE = 2'd0,
    CLS_NEAR      = 2'd1,
    CLS_DISTANT   = 2'd2,
    CLS_HIT       = 2'd3
  } insert_class_e;

  // One request as seen by the interval tuner
  typedef struct packed {
    logic             fire;
    logic             miss;
    logic [TickW-1:0] now;
  } tune_req_t;

  // Insertion confidence in hundredths, by miss-rate row and heat column
  localparam logic [0:7][0:7][AlphaW-1:0] FzTable = '{
    '{7'd90, 7'd90, 7'd92, 7'd94, 7'd96, 7'd98, 7'd99, 7'd100},
    '{7'd80, 7'd82, 7'd86, 7'd90, 7'd94, 7'd97, 7'd99, 7'd100},
    '{7'd60, 7'd65, 7'd75, 7'd82, 7'd90, 7'd95, 7'd98, 7'd100},
    '{7'd40, 7'd45, 7'd60, 7'd72, 7'd84, 7'd92, 7'd97, 7'd100},
    '{7'd20, 7'd25, 7'd45, 7'd62, 7'd78, 7'd90, 7'd96, 7'd100},
    '{7'd10, 7'd12, 7'd30, 7'd50, 7'd70, 7'd86, 7'd94, 7'd99},
    '{7'd5,  7'd8,  7'd20, 7'd40, 7'd62, 7'd82, 7'd92, 7'd98},
    '{7'd2,  7'd5,  7'd15, 7'd32, 7'd55, 7'd78, 7'd90, 7'd97}
  };

  function automatic logic [AlphaW-1:0] fz_alpha(input logic [RowW-1:0] row,
                                                 input logic [2:0] col);
    return FzTable[row][col];
  endfunction

endpackage

// ===== hw/rtl/fzrrip_tuner.sv =====
// Interval counters and miss-rate row retuning of the fuzzy RRIP policy.
`timescale 1ns / 1ps

module fzrrip_tuner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  fzrrip_pkg::tune_req_t             req_i,
  input  logic [fzrrip_pkg::CntW-1:0]       tune_interval_i,
  output logic [fzrrip_pkg::RowW-1:0]       miss_row_o
);

  logic [fzrrip_pkg::CntW-1:0]  miss_cnt_q, miss_cnt_d;
  logic [fzrrip_pkg::CntW-1:0]  acc_cnt_q, acc_cnt_d;
  logic [fzrrip_pkg::RowW-1:0]  row_q, row_d;
  logic [fzrrip_pkg::TickW-1:0] last_tick_q, last_tick_d;

  logic [fzrrip_pkg::CntW-1:0]  miss_inc, acc_inc, intv;
  logic [fzrrip_pkg::TickW:0]   next_sum;
  logic [fzrrip_pkg::TickW-1:0] next_tick;
  logic [39:0]                  scaled;
  logic [fzrrip_pkg::RowW-1:0]  new_row;
  logic                         retune;

  // Count the request with saturation
  assign acc_inc  = (&acc_cnt_q) ? acc_cnt_q : acc_cnt_q + 1'b1;
  assign miss_inc = (req_i.miss && !(&miss_cnt_q)) ? miss_cnt_q + 1'b1 : miss_cnt_q;

  // Saturating deadline of the current interval
  assign intv      = (tune_interval_i == '0) ? fzrrip_pkg::CntW'(1) : tune_interval_i;
  assign next_sum  = {1'b0, last_tick_q} + {33'b0, intv};
  assign next_tick = next_sum[fzrrip_pkg::TickW] ? '1 : next_sum[fzrrip_pkg::TickW-1:0];
  assign retune    = (req_i.now >= next_tick);

  // Row is the largest k up to 7 with k*accesses <= 20*misses
  assign scaled = {4'b0, miss_inc, 4'b0} + {6'b0, miss_inc, 2'b0};
  always_comb begin
    new_row = '0;
    for (int j = 1; j < 8; j++) begin
      if (40'(j) * {8'b0, acc_inc} <= scaled) begin
        new_row = fzrrip_pkg::RowW'(j);
      end
    end
  end

  // Advance counters, retune on interval end
  always_comb begin
    miss_cnt_d  = miss_cnt_q;
    acc_cnt_d   = acc_cnt_q;
    row_d       = row_q;
    last_tick_d = last_tick_q;
    if (req_i.fire) begin
      if (retune) begin
        if (acc_inc != '0) begin
          row_d = new_row;
        end
        miss_cnt_d  = '0;
        acc_cnt_d   = '0;
        last_tick_d = req_i.now;
      end else begin
        miss_cnt_d = miss_inc;
        acc_cnt_d  = acc_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_cnt_q  <= '0;
      acc_cnt_q   <= '0;
      row_q       <= fzrrip_pkg::MissRowRst;
      last_tick_q <= '0;
    end else begin
      miss_cnt_q  <= miss_cnt_d;
      acc_cnt_q   <= acc_cnt_d;
      row_q       <= row_d;
      last_tick_q <= last_tick_d;
    end
  end

  assign miss_row_o = row_q;

endmodule

// ===== hw/rtl/fuzzy_rrip_insertion_policy.sv =====
// Top level of the fuzzy RRIP insertion and promotion policy.
//
// Takes one hit or miss request per cycle while the result channel does not
// stall, and returns one result per request, in order. A request is registered
// on acceptance and moves to the result register once that register is free or
// its result is taken; the result then shows on the output until taken. The
// rate is set by the single logic stage between the input register and the
// result register (table lookup with the threshold compares, and the 64-bit
// interval deadline compare in the tuner). A stalled result holds the result
// register and the input register absorbs one more request. Configuration
// writes take effect at once and belong in idle periods.
`timescale 1ns / 1ps

module fuzzy_rrip_insertion_policy (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration write port
  input  logic                                cfg_we_i,
  input  logic [fzrrip_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fzrrip_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // Request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                func_i,
  input  logic [fzrrip_pkg::RrpvW-1:0]        line_rrpv_i,
  input  logic [fzrrip_pkg::HeatW-1:0]        line_heat_i,
  input  logic [fzrrip_pkg::TickW-1:0]        now_tick_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [fzrrip_pkg::RrpvW-1:0]        new_rrpv_o,
  output logic [fzrrip_pkg::HeatW-1:0]        new_heat_o,
  output logic [1:0]                          insert_class_o
);

  // Configuration registers
  logic [fzrrip_pkg::AlphaW-1:0] imm_thr_q;
  logic [fzrrip_pkg::AlphaW-1:0] near_thr_q;
  logic [fzrrip_pkg::CntW-1:0]   tune_intv_q;
  logic                          hit_zero_q;

  // Input register
  logic                          in_vld_q;
  logic                          func_q;
  logic [fzrrip_pkg::RrpvW-1:0]  rrpv_q;
  logic [fzrrip_pkg::HeatW-1:0]  heat_q;
  logic [fzrrip_pkg::TickW-1:0]  tick_q;

  // Result register
  logic                          out_vld_q;
  logic [fzrrip_pkg::RrpvW-1:0]  res_rrpv_q, res_rrpv_d;
  logic [fzrrip_pkg::HeatW-1:0]  res_heat_q, res_heat_d;
  fzrrip_pkg::insert_class_e     res_cls_q, res_cls_d;

  logic                          advance;
  logic                          in_fire;
  logic [fzrrip_pkg::RrpvW-1:0]  rrpv_clamp;
  logic [fzrrip_pkg::RowW-1:0]   miss_row;
  logic [fzrrip_pkg::AlphaW-1:0] alpha;
  fzrrip_pkg::tune_req_t         tune_req;

  // Move a request to the result register when that register frees up
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_thr_q   <= fzrrip_pkg::ImmThrRst;
      near_thr_q  <= fzrrip_pkg::NearThrRst;
      tune_intv_q <= fzrrip_pkg::TuneIntvRst;
      hit_zero_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fzrrip_pkg::CfgImmThr:   imm_thr_q   <= cfg_wdata_i[fzrrip_pkg::AlphaW-1:0];
        fzrrip_pkg::CfgNearThr:  near_thr_q  <= cfg_wdata_i[fzrrip_pkg::AlphaW-1:0];
        fzrrip_pkg::CfgTuneIntv: tune_intv_q <= cfg_wdata_i;
        fzrrip_pkg::CfgHitZero:  hit_zero_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Capture the request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      func_q <= func_i;
      rrpv_q <= line_rrpv_i;
      heat_q <= line_heat_i;
      tick_q <= now_tick_i;
    end
  end

  // Interval counters see each request as it leaves the input register
  assign tune_req.fire = advance;
  assign tune_req.miss = func_q;
  assign tune_req.now  = tick_q;

  fzrrip_tuner u_tuner (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (tune_req),
    .tune_interval_i (tune_intv_q),
    .miss_row_o      (miss_row)
  );

  // Promote on a hit, classify on a miss using the row held before this request
  assign rrpv_clamp = (rrpv_q > fzrrip_pkg::RrpvMax) ? fzrrip_pkg::RrpvMax : rrpv_q;
  assign alpha      = fzrrip_pkg::fz_alpha(miss_row, heat_q[fzrrip_pkg::HeatW-1:2]);

  always_comb begin
    if (!func_q) begin
      if (hit_zero_q) begin
        res_rrpv_d = '0;
      end else if (rrpv_clamp != '0) begin
        res_rrpv_d = rrpv_clamp - 1'b1;
      end else begin
        res_rrpv_d = '0;
      end
      if (8'(heat_q) < 8'(fzrrip_pkg::HeatMax)) begin
        res_heat_d = heat_q + 1'b1;
      end else begin
        res_heat_d = heat_q;
      end
      res_cls_d = fzrrip_pkg::CLS_HIT;
    end else begin
      priority if (alpha > imm_thr_q) begin
        res_rrpv_d = '0;
        res_cls_d  = fzrrip_pkg::CLS_IMMEDIATE;
      end else if (alpha > near_thr_q) begin
        res_rrpv_d = fzrrip_pkg::RrpvMax - 1'b1;
        res_cls_d  = fzrrip_pkg::CLS_NEAR;
      end else begin
        res_rrpv_d = fzrrip_pkg::RrpvMax;
        res_cls_d  = fzrrip_pkg::CLS_DISTANT;
      end
      res_heat_d = (heat_q != '0) ? fzrrip_pkg::HeatW'(1) : '0;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (!out_vld_q || out_ready_i) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_rrpv_q <= res_rrpv_d;
      res_heat_q <= res_heat_d;
      res_cls_q  <= res_cls_d;
    end
  end

  assign out_valid_o    = out_vld_q;
  assign new_rrpv_o     = res_rrpv_q;
  assign new_heat_o     = res_heat_q;
  assign insert_class_o = res_cls_q;

endmodule
